// ===== hdl/adjacency_matrix_connectivity_check_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency matrix connectivity check
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_CONNECTIVITY_CHECK_DEFINES_SVH
`define ADJACENCY_MATRIX_CONNECTIVITY_CHECK_DEFINES_SVH

// same-cycle implication
`define AMCC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/amcc_pkg.sv =====
// ----------------------------------------------------------------------------
// amcc_pkg
// Types and constants of the adjacency matrix connectivity check.
// ----------------------------------------------------------------------------
package amcc_pkg;

  localparam int unsigned ROW_BITS  = 32;  // bits per adjacency row
  localparam int unsigned RIDX_W    = 5;   // row index width
  localparam int unsigned CNT_W     = 6;   // vertex count width
  localparam int unsigned CFG_IDX_W = 1;   // config register index width
  localparam int unsigned CFG_DW    = 6;   // config write data width

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC    = 1'b1;

  localparam logic [CNT_W-1:0] VCOUNT_RST = 6'd32;

  // queued command from front to back
  typedef struct packed {
    logic                wr;    // row lands in the store
    logic                eval;  // run the closure walk after the write
    logic [RIDX_W-1:0]   idx;
    logic [ROW_BITS-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] vcount;
    logic             sym;
  } cfg_t;

  typedef struct packed {
    logic eval;  // closure walk in progress
    logic resp;  // verdict waiting for the output register
  } bstat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EVAL,
    B_RESP
  } bstate_e;

endpackage

// ===== hdl/amcc_row_if.sv =====
// ----------------------------------------------------------------------------
// amcc_row_if
// Row channel: one adjacency row per beat.
// ----------------------------------------------------------------------------
interface amcc_row_if;
  logic                              valid;
  logic                              ready;
  logic [amcc_pkg::RIDX_W-1:0]       row_index;
  logic [amcc_pkg::ROW_BITS-1:0]     row_edges;
  logic                              last_row;

  modport source (output valid, row_index, row_edges, last_row, input ready);
  modport sink   (input valid, row_index, row_edges, last_row, output ready);
endinterface

// ===== hdl/amcc_res_if.sv =====
// ----------------------------------------------------------------------------
// amcc_res_if
// Result channel: one connectivity verdict per beat.
// ----------------------------------------------------------------------------
interface amcc_res_if;
  logic valid;
  logic ready;
  logic connected;

  modport source (output valid, connected, input ready);
  modport sink   (input valid, connected, output ready);
endinterface

// ===== hdl/amcc_ram.sv =====
// ----------------------------------------------------------------------------
// amcc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module amcc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/amcc_front.sv =====
// ----------------------------------------------------------------------------
// amcc_front
// Accepts row beats, tags them for store write and evaluation, and
// buffers them in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module amcc_front #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  amcc_row_if.sink          row,
  output logic              q_valid_o,
  output amcc_pkg::cmd_t    q_data_o,
  input  logic              q_pop_i
);

  amcc_pkg::cmd_t mem_q [2];
  amcc_pkg::cmd_t cmd;
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push;

  // rows past the store are dropped, but a last row still evaluates
  always_comb begin
    cmd.wr   = 32'(row.row_index) < MAX_VERTICES;
    cmd.eval = row.last_row;
    cmd.idx  = row.row_index;
    cmd.row  = row.row_edges;
  end

  assign row.ready = (cnt_q != 2'd2);
  assign push      = row.valid && row.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ q_pop_i;
    cnt_d  = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== hdl/amcc_back.sv =====
// ----------------------------------------------------------------------------
// amcc_back
// Row store and closure walk. Sweeps the stored rows, growing the set
// reached from vertex 0 (forward) and, unless symmetric, the set reaching vertex 0 (backward),
// until a full sweep changes nothing; then posts the verdict.
// ----------------------------------------------------------------------------
module amcc_back #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  amcc_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  amcc_pkg::cmd_t    q_data_i,
  output logic              q_pop_o,
  amcc_res_if.source        res,
  output amcc_pkg::bstat_t  stat_o
);

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned LIM = (MAX_VERTICES < amcc_pkg::ROW_BITS) ?
                                MAX_VERTICES : amcc_pkg::ROW_BITS;
  localparam int unsigned RW  = amcc_pkg::RIDX_W;
  localparam int unsigned NB  = amcc_pkg::ROW_BITS;
  localparam int unsigned CW  = amcc_pkg::CNT_W;

  amcc_pkg::bstate_e state_q, state_d;

  logic [RW-1:0] rd_q, rd_d;          // next row to read
  logic          iss_q, iss_d;        // read issue active
  logic          pv_q, pv_d;          // row data arriving this cycle
  logic [RW-1:0] pv_idx_q, pv_idx_d;
  logic          pv_last_q, pv_last_d;
  logic [NB-1:0] f_q, f_d;            // reached from vertex 0
  logic [NB-1:0] b_q, b_d;            // reaching vertex 0
  logic          chg_q, chg_d;        // sweep changed a set
  logic          res_q, res_d;
  logic          out_vld_q, out_vld_d;
  logic          out_con_q, out_con_d;

  logic [CW-1:0] n_eff;
  logic [NB-1:0] mask;
  logic          last_rd;
  logic          we;
  logic [NB-1:0] rdata;
  logic [NB-1:0] row_m;
  logic [NB-1:0] vbit;
  logic [NB-1:0] f_upd, b_upd;
  logic          chg_now, again, full_ok;

  amcc_ram #(
    .WIDTH (NB),
    .DEPTH (MAX_VERTICES)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(q_data_i.idx)),
    .wdata_i (q_data_i.row),
    .raddr_i (AW'(rd_q)),
    .rdata_o (rdata)
  );

  // vertex count clamp: zero counts as one, saturate at the smaller of the store depth and the row width
  always_comb begin
    if (cfg_i.vcount == '0) begin
      n_eff = CW'(1);
    end else if (32'(cfg_i.vcount) > LIM) begin
      n_eff = CW'(LIM);
    end else begin
      n_eff = cfg_i.vcount;
    end
    mask = (32'(n_eff) >= NB) ? '1 : ((NB'(1) << n_eff) - NB'(1));
  end

  assign last_rd = ({1'b0, rd_q} == (n_eff - CW'(1)));

  // set update for the row arriving from the store
  always_comb begin
    row_m = rdata & mask;
    vbit  = NB'(1) << pv_idx_q;
    f_upd = f_q | (f_q[pv_idx_q] ? row_m : '0);
    b_upd = b_q;
    if (cfg_i.sym) begin
      f_upd = f_upd | ((|(row_m & f_q)) ? vbit : '0);
    end else begin
      b_upd = b_q | ((|(row_m & b_q)) ? vbit : '0);
    end
    chg_now = (f_upd != f_q) || (b_upd != b_q);
    again   = chg_q || chg_now;
    full_ok = (f_upd == mask) && (cfg_i.sym || (b_upd == mask));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      amcc_pkg::B_IDLE: begin
        if (q_valid_i && q_data_i.eval) state_d = amcc_pkg::B_EVAL;
      end
      amcc_pkg::B_EVAL: begin
        if (pv_q && pv_last_q && !again) state_d = amcc_pkg::B_RESP;
      end
      amcc_pkg::B_RESP: begin
        if (!out_vld_q || res.ready) state_d = amcc_pkg::B_IDLE;
      end
      default: state_d = amcc_pkg::B_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop_o   = 1'b0;
    we        = 1'b0;
    rd_d      = rd_q;
    iss_d     = iss_q;
    pv_d      = 1'b0;
    pv_idx_d  = rd_q;
    pv_last_d = last_rd;
    f_d       = f_q;
    b_d       = b_q;
    chg_d     = chg_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && !res.ready;
    out_con_d = out_con_q;
    case (state_q)
      amcc_pkg::B_IDLE: begin
        q_pop_o = q_valid_i;
        we      = q_valid_i && q_data_i.wr;
        if (q_valid_i && q_data_i.eval) begin
          f_d   = NB'(1);
          b_d   = NB'(1);
          rd_d  = '0;
          iss_d = 1'b1;
          chg_d = 1'b0;
        end
      end
      amcc_pkg::B_EVAL: begin
        if (iss_q) begin
          pv_d = 1'b1;
          rd_d = rd_q + RW'(1);
          if (last_rd) iss_d = 1'b0;
        end
        if (pv_q) begin
          f_d = f_upd;
          b_d = b_upd;
          if (pv_last_q) begin
            if (again) begin
              rd_d  = '0;
              iss_d = 1'b1;
              chg_d = 1'b0;
            end else begin
              res_d = full_ok;
            end
          end else begin
            chg_d = again;
          end
        end
      end
      amcc_pkg::B_RESP: begin
        if (!out_vld_q || res.ready) begin
          out_vld_d = 1'b1;
          out_con_d = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= amcc_pkg::B_IDLE;
      iss_q     <= 1'b0;
      pv_q      <= 1'b0;
      chg_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      pv_q      <= pv_d;
      chg_q     <= chg_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q      <= rd_d;
    pv_idx_q  <= pv_idx_d;
    pv_last_q <= pv_last_d;
    f_q       <= f_d;
    b_q       <= b_d;
    res_q     <= res_d;
    out_con_q <= out_con_d;
  end

  assign res.valid     = out_vld_q;
  assign res.connected = out_con_q;
  assign stat_o.eval   = (state_q == amcc_pkg::B_EVAL);
  assign stat_o.resp   = (state_q == amcc_pkg::B_RESP);

endmodule

// ===== hdl/adjacency_matrix_connectivity_check.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_connectivity_check
// Strong connectivity check over adjacency rows streamed one per beat.
//
//   channel   dir  handshake     payload
//   row_i     in   valid/ready   row_index[4:0], row_edges[31:0], last_row
//   res_o     out  valid/ready   connected
//   cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i[5:0]
//
// Rows are taken one beat per cycle while the queue has room and written
// to the row store in order. A last_row beat starts the closure walk:
// sweeps of n row reads (n is the clamped vertex count) through the single
// read port of the row store, repeated until a sweep adds no vertex. Rows
// keep queuing during the walk until the two-entry queue fills. Reset
// clears control only; the row store holds whatever it held and needs no
// clearing pass.
// ----------------------------------------------------------------------------
`include "adjacency_matrix_connectivity_check_defines.svh"

module adjacency_matrix_connectivity_check #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  amcc_row_if.sink                            row_i,
  amcc_res_if.source                          res_o,
  input  logic                                cfg_we_i,
  input  logic [amcc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [amcc_pkg::CFG_DW-1:0]         cfg_data_i
);

  // configuration registers
  logic [amcc_pkg::CNT_W-1:0] vcount_q, vcount_d;
  logic                       sym_q, sym_d;
  amcc_pkg::cfg_t             cfg;

  // front to back queue
  logic                       q_valid;
  amcc_pkg::cmd_t             q_data;
  logic                       q_pop;
  amcc_pkg::bstat_t           bst;

  always_comb begin
    vcount_d = vcount_q;
    sym_d    = sym_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        amcc_pkg::CFG_VERTEX_COUNT: vcount_d = cfg_data_i;
        amcc_pkg::CFG_SYMMETRIC:    sym_d    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= amcc_pkg::VCOUNT_RST;
      sym_q    <= 1'b0;
    end else begin
      vcount_q <= vcount_d;
      sym_q    <= sym_d;
    end
  end

  assign cfg.vcount = vcount_q;
  assign cfg.sym    = sym_q;

  // front: accept and tag rows
  amcc_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .row       (row_i),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  // back: row store, closure walk, result register
  amcc_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .res       (res_o),
    .stat_o    (bst)
  );

  // checks
  `AMCC_ASSERT_IMPLY(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
  `AMCC_ASSERT_IMPLY(a_no_pop_in_walk, bst.eval, !q_pop, "queue popped during walk")
  `AMCC_ASSERT_NEXT(a_last_starts_walk, q_pop && q_data.eval, bst.eval, "walk did not start")
  `AMCC_ASSERT_IMPLY(a_result_from_resp, $rose(res_o.valid), $past(bst.resp), "stray result")

endmodule
